// ===== rtl/dbc_pkg.sv =====
// Shared types and constants of the DMA buffer cache.
// Used by dbc_cell, dbc_qmem and dma_buffer_cache_ttl; depends on nothing.
package dbc_pkg;

  localparam int ENTRIES     = 64;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int QUEUE_DEPTH = 256;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int LIFE_W      = 6;

  localparam logic [LIFE_W-1:0] LIFE_LONG  = 6'd32;
  localparam logic [LIFE_W-1:0] LIFE_SHORT = 6'd2;
  localparam logic [LIFE_W-1:0] LIFE_FETCH = 6'd3;
  localparam logic [31:0]       ALIGN_MASK = 32'hFFFF_FFF0;

  localparam logic [2:0] REG_SHORT_COUNT = 3'd0;
  localparam logic [2:0] REG_TOTAL_COUNT = 3'd1;
  localparam logic [2:0] REG_SHORT_BUF   = 3'd2;
  localparam logic [2:0] REG_LONG_BUF    = 3'd3;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_TICK = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_TICK, S_SCAN, S_DECIDE, S_MEM, S_UPDATE, S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0]       tag;
    logic [LIFE_W-1:0] life;
    logic [QP_W-1:0]   qpos;
  } entry_t;

  typedef struct packed {
    logic             shift;
    logic             init;
    logic [CNT_W-1:0] s_eff;
    logic [CNT_W-1:0] t_eff;
  } cell_ctl_t;

endpackage

// ===== rtl/dbc_cell.sv =====
// One entry cell of the rotating entry ring.
// Depends on dbc_pkg.
module dbc_cell (
  input  logic                     clk_i,
  input  dbc_pkg::cell_ctl_t       ctl_i,
  input  logic [dbc_pkg::IDX_W-1:0] idx_i,
  input  dbc_pkg::entry_t          next_i,
  output dbc_pkg::entry_t          ent_o
);
  import dbc_pkg::*;

  entry_t           ent_q;
  logic [CNT_W-1:0] idx_ext;
  entry_t           init_val;

  assign idx_ext = CNT_W'(idx_i);

  // Reset image of the entry with this index for the current pool counts.
  always_comb begin
    init_val.tag  = '0;
    init_val.life = '0;
    if (idx_ext < ctl_i.s_eff) begin
      init_val.qpos = QP_W'(idx_ext);
    end else if (idx_ext < ctl_i.t_eff) begin
      init_val.qpos = QP_W'(idx_ext - ctl_i.s_eff);
    end else begin
      init_val.qpos = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      ent_q <= init_val;
    end else if (ctl_i.shift) begin
      ent_q <= next_i;
    end
  end

  assign ent_o = ent_q;

endmodule

// ===== rtl/dbc_qmem.sv =====
// Reuse queue storage: one write port, one registered read port.
// Depends on dbc_pkg.
module dbc_qmem (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [dbc_pkg::QP_W-1:0] waddr_i,
  input  logic [dbc_pkg::QP_W-1:0] wdata_i,
  input  logic [dbc_pkg::QP_W-1:0] raddr_i,
  output logic [dbc_pkg::QP_W-1:0] rdata_o
);
  import dbc_pkg::*;

  logic [QP_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dma_buffer_cache_ttl.sv =====
// Top level of the DMA staging buffer cache with short- and long-lived pools.
// Depends on dbc_pkg, dbc_cell and dbc_qmem.
//
// A request is taken when start is high while busy is low; its single result
// appears for exactly one cycle with done_o high, and the receiver cannot stall
// it. The entry state lives in a ring of ENTRIES cells that rotates by one
// entry per cycle during a tick, a search or a write-back, past a single
// compare unit at its head. A tick takes one ring rotation. A buffer request
// takes one rotation to search, the S_DECIDE and S_MEM states to decide and
// touch the reuse queue, and a second rotation to write the chosen entry back.
// After reset, and after every write of short_count or total_count, the block
// runs a pass over all QUEUE_DEPTH queue slots that rebuilds both reuse queues;
// busy stays high meanwhile and cfg_ready_o holds off configuration writes; it
// is also low while start offers a request. Size registers take effect at once.
module dma_buffer_cache_ttl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] dev_addr_i,
  input  logic [15:0] req_bytes_i,
  input  logic        long_lived_i,
  input  logic [5:0]  hint_index_i,
  input  logic [2:0]  medium_req_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [5:0]  buf_index_o,
  output logic [15:0] buf_offset_o,
  output logic [5:0]  hint_out_o,
  output logic [31:0] fetch_addr_o,
  output logic [15:0] fetch_bytes_o,
  output logic [2:0]  fetch_medium_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import dbc_pkg::*;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CNT_W-1:0] short_count_q, total_count_q;
  logic [15:0]      sbuf_q, lbuf_q;
  logic [CNT_W-1:0] s_eff, t_eff, l_cnt;

  // Queue pointers and pass counters.
  logic [QP_W-1:0]  srd_q, swr_q, lrd_q, lwr_q;
  logic [QP_W-1:0]  sweep_q;
  logic [IDX_W-1:0] cnt_q;
  logic             last_step;

  // Latched request.
  logic [31:0] dev_q;
  logic [15:0] req_q;
  logic        lng_q;
  logic [5:0]  hint_q;
  logic [2:0]  med_q;

  // Search records: first long hit, hinted short hit, first short hit.
  logic             lf_q, hf_q, sf_q;
  logic [IDX_W-1:0] li_q, si_q;
  logic             ll0_q, hl0_q, sl0_q;
  logic [QP_W-1:0]  lp_q, hp_q, sp_q;
  logic [15:0]      lo_q, ho_q, so_q;

  // Decision and pending entry updates.
  logic             uq_en_q, uq_long_q, alloc_q, alloc_long_q;
  logic [QP_W-1:0]  uq_pos_q;
  logic             t1_en_q, t1_tag_q, t2_en_q;
  logic [IDX_W-1:0] t1_idx_q, t2_idx_q;
  logic [LIFE_W-1:0] t1_life_q;
  logic [QP_W-1:0]  t2_pos_q;

  // Result registers.
  status_e     res_status_q;
  logic [5:0]  res_idx_q, res_hint_q;
  logic [15:0] res_off_q, res_fbytes_q;
  logic [31:0] res_faddr_q;
  logic [2:0]  res_fmed_q;

  // Ring.
  cell_ctl_t  ctl;
  entry_t     ents [ENTRIES];
  entry_t     head, head_new;
  logic [CNT_W-1:0] head_ext;
  logic       in_short, in_long, cov;
  logic [31:0] diff;
  logic [15:0] size;

  // Queue memories.
  logic            sq_we, lq_we;
  logic [QP_W-1:0] sq_wa, sq_wd, lq_wa, lq_wd, sq_rd, lq_rd;
  logic [QP_W-1:0] mover, alloc_raw;
  logic [IDX_W-1:0] alloc_idx;

  logic accept, sl, lne, sne;

  assign s_eff = (short_count_q > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : short_count_q;
  assign t_eff = (total_count_q > CNT_W'(ENTRIES)) ? CNT_W'(ENTRIES) : total_count_q;
  assign l_cnt = (t_eff > s_eff) ? (t_eff - s_eff) : '0;

  assign last_step = (cnt_q == IDX_W'(ENTRIES - 1));
  assign accept    = start && (state_q == S_IDLE);

  // The entry at the head of the ring is always entry cnt_q, since every pass
  // starts and ends with entry zero at the head.
  assign head     = ents[0];
  assign head_ext = CNT_W'(cnt_q);
  assign in_short = head_ext < s_eff;
  assign in_long  = !in_short && (head_ext < t_eff);
  assign size     = in_short ? sbuf_q : lbuf_q;
  assign diff     = dev_q - head.tag;
  assign cov      = !diff[31] && (req_q <= size) && (diff <= {16'b0, size - req_q});

  assign sl  = lng_q || (CNT_W'(hint_q) >= s_eff);
  assign lne = (lrd_q != lwr_q);
  assign sne = (srd_q != swr_q);

  assign mover     = uq_long_q ? lq_rd : sq_rd;
  assign alloc_raw = alloc_long_q ? lq_rd : sq_rd;
  assign alloc_idx = (alloc_raw >= QP_W'(ENTRIES)) ? '0 : alloc_raw[IDX_W-1:0];

  // Value written back into the tail of the ring for the head entry.
  always_comb begin
    head_new = head;
    if (state_q == S_TICK) begin
      if ((in_short || in_long) && head.life != '0) begin
        head_new.life = head.life - 1'b1;
        if (head.life == LIFE_W'(1)) begin
          head_new.qpos = in_short ? swr_q : lwr_q;
        end
      end
    end else if (state_q == S_UPDATE) begin
      if (t1_en_q && cnt_q == t1_idx_q) begin
        head_new.life = t1_life_q;
        if (t1_tag_q) begin
          head_new.tag = dev_q & ALIGN_MASK;
        end
      end
      if (t2_en_q && cnt_q == t2_idx_q) begin
        head_new.qpos = t2_pos_q;
      end
    end
  end

  for (genvar j = 0; j < ENTRIES; j++) begin : g_ring
    entry_t nxt;
    if (j == ENTRIES - 1) begin : g_tail
      assign nxt = head_new;
    end else begin : g_mid
      assign nxt = ents[j+1];
    end
    dbc_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .idx_i  (IDX_W'(j)),
      .next_i (nxt),
      .ent_o  (ents[j])
    );
  end

  // Queue write ports: rebuild sweep, aging, and removal by swap.
  always_comb begin
    sq_we = 1'b0;
    sq_wa = '0;
    sq_wd = '0;
    lq_we = 1'b0;
    lq_wa = '0;
    lq_wd = '0;
    unique case (state_q)
      S_INIT: begin
        sq_we = 1'b1;
        sq_wa = sweep_q;
        sq_wd = (sweep_q < QP_W'(s_eff)) ? sweep_q : '0;
        lq_we = 1'b1;
        lq_wa = sweep_q;
        lq_wd = (sweep_q < QP_W'(l_cnt)) ? (QP_W'(s_eff) + sweep_q) : '0;
      end
      S_TICK: begin
        if ((in_short || in_long) && head.life == LIFE_W'(1)) begin
          if (in_short) begin
            sq_we = 1'b1;
            sq_wa = swr_q;
            sq_wd = QP_W'(cnt_q);
          end else begin
            lq_we = 1'b1;
            lq_wa = lwr_q;
            lq_wd = QP_W'(cnt_q);
          end
        end
      end
      S_MEM: begin
        if (uq_en_q) begin
          if (uq_long_q && uq_pos_q != lrd_q) begin
            lq_we = 1'b1;
            lq_wa = uq_pos_q;
            lq_wd = mover;
          end else if (!uq_long_q && uq_pos_q != srd_q) begin
            sq_we = 1'b1;
            sq_wa = uq_pos_q;
            sq_wd = mover;
          end
        end
      end
      default: begin
      end
    endcase
  end

  dbc_qmem u_short_q (
    .clk_i   (clk_i),
    .we_i    (sq_we),
    .waddr_i (sq_wa),
    .wdata_i (sq_wd),
    .raddr_i (srd_q),
    .rdata_o (sq_rd)
  );

  dbc_qmem u_long_q (
    .clk_i   (clk_i),
    .we_i    (lq_we),
    .waddr_i (lq_wa),
    .wdata_i (lq_wd),
    .raddr_i (lrd_q),
    .rdata_o (lq_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:   if (sweep_q == QP_W'(QUEUE_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_d = cmd_i ? S_SCAN : S_TICK;
        end else if (cfg_valid_i && (cfg_index_i == REG_SHORT_COUNT ||
                                     cfg_index_i == REG_TOTAL_COUNT)) begin
          state_d = S_INIT;
        end
      end
      S_TICK:   if (last_step) state_d = S_DONE;
      S_SCAN:   if (last_step) state_d = S_DECIDE;
      S_DECIDE: state_d = S_MEM;
      S_MEM:    state_d = S_UPDATE;
      S_UPDATE: if (last_step) state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_INIT;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctl.shift   = (state_q == S_TICK) || (state_q == S_SCAN) || (state_q == S_UPDATE);
    ctl.init    = (state_q == S_INIT);
    ctl.s_eff   = s_eff;
    ctl.t_eff   = t_eff;
    busy        = (state_q != S_IDLE);
    cfg_ready_o = (state_q == S_IDLE) && !start;
    done_o      = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      short_count_q <= 7'd32;
      total_count_q <= 7'd48;
      sbuf_q        <= 16'd1024;
      lbuf_q        <= 16'd1024;
      srd_q         <= '0;
      swr_q         <= '0;
      lrd_q         <= '0;
      lwr_q         <= '0;
      sweep_q       <= '0;
      cnt_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_SHORT_COUNT: short_count_q <= cfg_data_i[CNT_W-1:0];
          REG_TOTAL_COUNT: total_count_q <= cfg_data_i[CNT_W-1:0];
          REG_SHORT_BUF:   sbuf_q <= cfg_data_i;
          REG_LONG_BUF:    lbuf_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (state_q == S_INIT) begin
        sweep_q <= sweep_q + 1'b1;
        srd_q   <= '0;
        swr_q   <= QP_W'(s_eff);
        lrd_q   <= '0;
        lwr_q   <= QP_W'(l_cnt);
      end
      if (ctl.shift) begin
        cnt_q <= last_step ? '0 : cnt_q + 1'b1;
      end
      if (sq_we && state_q == S_TICK) swr_q <= swr_q + 1'b1;
      if (lq_we && state_q == S_TICK) lwr_q <= lwr_q + 1'b1;
      if (state_q == S_MEM) begin
        if ((uq_en_q && uq_long_q) || (alloc_q && alloc_long_q)) lrd_q <= lrd_q + 1'b1;
        if ((uq_en_q && !uq_long_q) || (alloc_q && !alloc_long_q)) srd_q <= srd_q + 1'b1;
      end
    end
  end

  // Request datapath: search records, decision and result fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dev_q        <= dev_addr_i;
      req_q        <= req_bytes_i;
      lng_q        <= long_lived_i;
      hint_q       <= hint_index_i;
      med_q        <= medium_req_i;
      lf_q         <= 1'b0;
      hf_q         <= 1'b0;
      sf_q         <= 1'b0;
      res_status_q <= ST_TICK;
      res_idx_q    <= '0;
      res_off_q    <= '0;
      res_hint_q   <= hint_index_i;
      res_faddr_q  <= '0;
      res_fbytes_q <= '0;
      res_fmed_q   <= '0;
    end
    if (state_q == S_SCAN && cov) begin
      if (in_long && !lf_q) begin
        lf_q  <= 1'b1;
        li_q  <= cnt_q;
        ll0_q <= (head.life == '0);
        lp_q  <= head.qpos;
        lo_q  <= diff[15:0];
      end
      if (in_short && !sf_q) begin
        sf_q  <= 1'b1;
        si_q  <= cnt_q;
        sl0_q <= (head.life == '0);
        sp_q  <= head.qpos;
        so_q  <= diff[15:0];
      end
      if (in_short && cnt_q == hint_q) begin
        hf_q  <= 1'b1;
        hl0_q <= (head.life == '0);
        hp_q  <= head.qpos;
        ho_q  <= diff[15:0];
      end
    end
    if (state_q == S_DECIDE) begin
      uq_en_q <= 1'b0;
      alloc_q <= 1'b0;
      t1_en_q <= 1'b0;
      t2_en_q <= 1'b0;
      t1_tag_q <= 1'b0;
      priority if (sl && lf_q) begin
        // Long-pool hit.
        res_status_q <= ST_HIT;
        res_idx_q    <= li_q;
        res_off_q    <= lo_q;
        res_hint_q   <= li_q;
        t1_en_q      <= 1'b1;
        t1_idx_q     <= li_q;
        t1_life_q    <= LIFE_LONG;
        uq_en_q      <= ll0_q && lne;
        uq_long_q    <= 1'b1;
        uq_pos_q     <= lp_q;
      end else if (lng_q && lne) begin
        alloc_q      <= 1'b1;
        alloc_long_q <= 1'b1;
      end else if (!lng_q && (hf_q || sf_q)) begin
        // Short-pool hit; the hinted entry wins over the first in order.
        res_status_q <= ST_HIT;
        res_idx_q    <= hf_q ? hint_q : si_q;
        res_off_q    <= hf_q ? ho_q : so_q;
        t1_en_q      <= 1'b1;
        t1_idx_q     <= hf_q ? hint_q : si_q;
        t1_life_q    <= LIFE_SHORT;
        uq_en_q      <= hf_q ? hl0_q : sl0_q;
        uq_long_q    <= 1'b0;
        uq_pos_q     <= hf_q ? hp_q : sp_q;
      end else if (sne) begin
        alloc_q      <= 1'b1;
        alloc_long_q <= 1'b0;
      end else begin
        res_status_q <= ST_FULL;
      end
    end
    if (state_q == S_MEM) begin
      if (uq_en_q && mover < QP_W'(ENTRIES) &&
          uq_pos_q != (uq_long_q ? lrd_q : srd_q)) begin
        t2_en_q  <= 1'b1;
        t2_idx_q <= mover[IDX_W-1:0];
        t2_pos_q <= uq_pos_q;
      end
      if (alloc_q) begin
        // Miss: the entry taken from the reuse queue gets a fresh fetch.
        res_status_q <= ST_MISS;
        res_idx_q    <= alloc_idx;
        res_off_q    <= {12'b0, dev_q[3:0]};
        res_hint_q   <= alloc_idx;
        res_faddr_q  <= dev_q & ALIGN_MASK;
        res_fbytes_q <= (CNT_W'(alloc_idx) < s_eff) ? sbuf_q : lbuf_q;
        res_fmed_q   <= med_q;
        t1_en_q      <= 1'b1;
        t1_idx_q     <= alloc_idx;
        t1_life_q    <= LIFE_FETCH;
        t1_tag_q     <= 1'b1;
      end
    end
  end

  assign status_o       = res_status_q;
  assign buf_index_o    = res_idx_q;
  assign buf_offset_o   = res_off_q;
  assign hint_out_o     = res_hint_q;
  assign fetch_addr_o   = res_faddr_q;
  assign fetch_bytes_o  = res_fbytes_q;
  assign fetch_medium_o = res_fmed_q;

endmodule
